// ----- src/kwm_pkg.sv -----
// shared types and codes for the k-way sorted merge block
package kwm_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned INDEX_W = 3;

	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_POP  = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} kwm_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_COMMIT,
		ST_DONE
	} kwm_state_t;

endpackage

// ----- src/kwm_if.sv -----
// request and response channel interfaces of the k-way sorted merge block
interface kwm_req_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 req_type;
	logic [kwm_pkg::INDEX_W-1:0]          list_index;
	logic signed [kwm_pkg::VALUE_W-1:0]   element_value;

	modport source (output valid, output req_type, output list_index, output element_value,
		input ready);
	modport sink (input valid, input req_type, input list_index, input element_value,
		output ready);
endinterface

interface kwm_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [kwm_pkg::VALUE_W-1:0]   out_value;
	logic [kwm_pkg::INDEX_W-1:0]          out_list;
	logic [1:0]                           status;

	modport source (output valid, output out_value, output out_list, output status,
		input ready);
	modport sink (input valid, input out_value, input out_list, input status,
		output ready);
endinterface

// ----- src/kwm_queues.sv -----
// list storage memory with per-list head, tail and fill registers
module kwm_queues #(
	parameter int unsigned NUM_LISTS  = 8,
	parameter int unsigned LIST_DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push_en,
	input  logic [$clog2(NUM_LISTS)-1:0]        push_sel,
	input  logic [kwm_pkg::VALUE_W-1:0]         push_data,
	output logic                                push_full,
	input  logic [$clog2(NUM_LISTS)-1:0]        rd_sel,
	output logic [kwm_pkg::VALUE_W-1:0]         rd_data,
	input  logic                                pop_en,
	input  logic [$clog2(NUM_LISTS)-1:0]        pop_sel,
	output logic [NUM_LISTS-1:0]                nonempty
);

	localparam int unsigned LW = $clog2(NUM_LISTS);
	localparam int unsigned PW = $clog2(LIST_DEPTH);
	localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
	localparam int unsigned AW = LW + PW;
	localparam int unsigned MEM_DEPTH = NUM_LISTS * (1 << PW);

	logic [kwm_pkg::VALUE_W-1:0] mem_q [MEM_DEPTH];
	logic [PW-1:0]               head_q [NUM_LISTS];
	logic [PW-1:0]               tail_q [NUM_LISTS];
	logic [CW-1:0]               fill_q [NUM_LISTS];

	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		logic [PW-1:0] r;
		if (p == PW'(LIST_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PW'(1);
		end
		return r;
	endfunction

	assign wr_addr   = {push_sel, tail_q[push_sel]};
	assign rd_addr   = {rd_sel, head_q[rd_sel]};
	assign push_full = (fill_q[push_sel] == CW'(LIST_DEPTH));

	always_comb begin
		for (int i = 0; i < NUM_LISTS; i++) begin
			nonempty[i] = (fill_q[i] != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			mem_q[wr_addr] <= push_data;
		end
		rd_data <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LISTS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else begin
			if (push_en) begin
				tail_q[push_sel] <= ptr_inc(tail_q[push_sel]);
			end
			if (pop_en) begin
				head_q[pop_sel] <= ptr_inc(head_q[pop_sel]);
			end
			for (int i = 0; i < NUM_LISTS; i++) begin
				if (push_en && push_sel == LW'(i) && !(pop_en && pop_sel == LW'(i))) begin
					fill_q[i] <= fill_q[i] + CW'(1);
				end else if (pop_en && pop_sel == LW'(i)
					&& !(push_en && push_sel == LW'(i))) begin
					fill_q[i] <= fill_q[i] - CW'(1);
				end
			end
		end
	end

endmodule

// ----- src/k_way_sorted_merge.sv -----
// top level of the k-way sorted merge block: sequencer and shared head comparator
//
// req channel: one beat is a push (req_type 0) that appends element_value to the list
// list_index, or a pop (req_type 1) that removes the smallest head of all lists, ties
// going to the lower list index. rsp channel: exactly one beat per request, carrying
// out_value, out_list and status (0 ok, 1 pop with every list empty, 2 push refused
// because the list is full or the index is out of range).
// a push goes from idle straight to the done state, which loads its response.
// a pop passes through the scan, last and commit states before done: one shared
// signed comparator visits the head of one list per cycle, reading it through the
// single read port of the list memory, and commit pops the smallest head found.
// req.ready is high only while the sequencer is idle; a finished response waits in an
// output register, so the next request can be accepted while rsp is stalled, and the
// sequencer then holds its result until the output register frees up.
// reset clears all pointers and fill counts and drops any pending response; the list
// memory itself is not cleared, since only entries of nonempty lists are ever used.
module k_way_sorted_merge #(
	parameter int unsigned NUM_LISTS  = 8,
	parameter int unsigned LIST_DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	kwm_req_if.sink    req,
	kwm_rsp_if.source  rsp
);

	localparam int unsigned LW = $clog2(NUM_LISTS);
	localparam int unsigned IW = (LW > kwm_pkg::INDEX_W) ? LW : kwm_pkg::INDEX_W;

	kwm_pkg::kwm_state_t state_q, state_d;

	logic [LW-1:0]                      cnt_q;
	logic                               scan_s1;
	logic                               ne_s1;
	logic [LW-1:0]                      idx_s1;
	logic                               found_q;
	logic [LW-1:0]                      best_q;
	logic signed [kwm_pkg::VALUE_W-1:0] best_val_q;

	logic [kwm_pkg::VALUE_W-1:0]        res_value_q;
	logic [kwm_pkg::INDEX_W-1:0]        res_list_q;
	kwm_pkg::kwm_status_t               res_status_q;
	logic                               out_vld_q;

	logic                               accept;
	logic                               push_en;
	logic                               push_ok;
	logic                               push_full;
	logic                               in_range;
	logic [IW-1:0]                      push_idx;
	logic [LW-1:0]                      push_sel;
	logic [LW-1:0]                      rd_sel;
	logic [kwm_pkg::VALUE_W-1:0]        rd_data;
	logic                               pop_en;
	logic [NUM_LISTS-1:0]               nonempty;
	logic                               take;
	logic                               out_free;
	logic                               load_out;
	logic [IW-1:0]                      best_ext;

	assign accept   = req.valid && req.ready;
	assign push_idx = IW'(req.list_index);
	assign push_sel = push_idx[LW-1:0];
	assign in_range = ((IW + 1)'(push_idx) < (IW + 1)'(NUM_LISTS));
	assign push_ok  = in_range && !push_full;
	assign push_en  = accept && req.req_type == kwm_pkg::REQ_PUSH && push_ok;
	assign pop_en   = (state_q == kwm_pkg::ST_COMMIT) && found_q;
	assign rd_sel   = cnt_q;
	assign out_free = !out_vld_q || rsp.ready;
	assign take     = scan_s1 && ne_s1 && (!found_q || $signed(rd_data) < best_val_q);
	assign best_ext = IW'(best_q);

	kwm_queues #(
		.NUM_LISTS  (NUM_LISTS),
		.LIST_DEPTH (LIST_DEPTH)
	) u_queues (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_en   (push_en),
		.push_sel  (push_sel),
		.push_data (req.element_value),
		.push_full (push_full),
		.rd_sel    (rd_sel),
		.rd_data   (rd_data),
		.pop_en    (pop_en),
		.pop_sel   (best_q),
		.nonempty  (nonempty)
	);

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			kwm_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (req.req_type == kwm_pkg::REQ_POP) begin
						state_d = kwm_pkg::ST_SCAN;
					end else begin
						state_d = kwm_pkg::ST_DONE;
					end
				end
			end
			kwm_pkg::ST_SCAN: begin
				if (cnt_q == LW'(NUM_LISTS - 1)) begin
					state_d = kwm_pkg::ST_LAST;
				end
			end
			kwm_pkg::ST_LAST: begin
				state_d = kwm_pkg::ST_COMMIT;
			end
			kwm_pkg::ST_COMMIT: begin
				state_d = kwm_pkg::ST_DONE;
			end
			kwm_pkg::ST_DONE: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = kwm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = kwm_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= kwm_pkg::ST_IDLE;
			cnt_q     <= '0;
			scan_s1   <= 1'b0;
			found_q   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			scan_s1 <= (state_q == kwm_pkg::ST_SCAN);
			if (accept) begin
				cnt_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (state_q == kwm_pkg::ST_SCAN) begin
					cnt_q <= cnt_q + LW'(1);
				end
				if (take) begin
					found_q <= 1'b1;
				end
			end
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// scan datapath and result registers
	always_ff @(posedge clk) begin
		ne_s1  <= nonempty[cnt_q];
		idx_s1 <= cnt_q;
		if (take) begin
			best_q     <= idx_s1;
			best_val_q <= $signed(rd_data);
		end
		if (accept && req.req_type == kwm_pkg::REQ_PUSH) begin
			res_value_q  <= '0;
			res_list_q   <= '0;
			res_status_q <= push_ok ? kwm_pkg::STATUS_OK : kwm_pkg::STATUS_FULL;
		end
		if (state_q == kwm_pkg::ST_COMMIT) begin
			if (found_q) begin
				res_value_q  <= best_val_q;
				res_list_q   <= best_ext[kwm_pkg::INDEX_W-1:0];
				res_status_q <= kwm_pkg::STATUS_OK;
			end else begin
				res_value_q  <= '0;
				res_list_q   <= '0;
				res_status_q <= kwm_pkg::STATUS_EMPTY;
			end
		end
		if (load_out) begin
			rsp.out_value <= res_value_q;
			rsp.out_list  <= res_list_q;
			rsp.status    <= res_status_q;
		end
	end

	assign rsp.valid = out_vld_q;

	a_empty_pop_no_heads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == kwm_pkg::ST_COMMIT && !found_q) |-> (nonempty == '0))
		else $error("pop reported empty while a list holds data");

	a_pop_from_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop_en |-> nonempty[best_q])
		else $error("pop commit on an empty list");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		push_en |-> !push_full)
		else $error("push written into a full list");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(state_q == kwm_pkg::ST_DONE))
		else $error("response raised outside the done state");

endmodule
